// ===== hw/rtl/matrix3x3_inverse_assert.svh =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse assertion macros
// Shared wrappers for the concurrent checks of the inverter.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Overlapping implication, sampled on clock, off during reset.
`define MI3_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Widths, cofactor index table and shared types of the 3x3 inverter.
// ----------------------------------------------------------------------------
package mi3_pkg;

   localparam int ELEM_W  = 32;
   localparam int N_ELEM  = 9;
   localparam int COF_W   = 64;
   localparam int DET_W   = 98;
   localparam int THR_W   = 48;
   localparam int QBITS   = 32;
   localparam int FRONT_STAGES = 7;

   localparam logic [THR_W-1:0] THR_RESET = 48'd2814750;

   // cofactor i = m[a]*m[b] - m[c]*m[d], columns a, b, c, d
   localparam int COF_IDX [N_ELEM][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};

   typedef logic [N_ELEM-1:0][ELEM_W-1:0] mat_type;
   typedef logic [N_ELEM-1:0][COF_W-1:0]  cof_type;

   typedef struct packed {
      logic             valid;
      logic             singular;
      logic             dneg;
      logic [DET_W-1:0] dmag;
      cof_type          cof;
      mat_type          mat;
   } front_out_type;

endpackage

// ===== hw/rtl/mi3_front.sv =====
// ----------------------------------------------------------------------------
// mi3_front
// Cofactors, exact determinant, magnitude and singular test, 7 stages.
// ----------------------------------------------------------------------------
module mi3_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  mi3_pkg::mat_type                in_mat,
   input  logic [mi3_pkg::THR_W-1:0]       thr,
   output mi3_pkg::front_out_type          fo
);

   localparam int FS = mi3_pkg::FRONT_STAGES;

   logic [FS-1:0]                  vld_ff;
   mi3_pkg::mat_type               mat_ff [FS];
   logic signed [63:0]             prod_ff [18];
   mi3_pkg::cof_type               cof_ff [3:FS];
   logic signed [63:0]             ph_ff [3];
   logic signed [64:0]             pl_ff [3];
   logic signed [95:0]             pr_ff [3];
   logic signed [mi3_pkg::DET_W-1:0] det_ff;
   logic                           sing_ff;
   logic                           dneg_ff;
   logic [mi3_pkg::DET_W-1:0]      dmag_ff;
   logic [mi3_pkg::DET_W-1:0]      dmag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[FS-2:0], in_valid};
      end
   end

   assign dmag_in = det_ff[mi3_pkg::DET_W-1] ? mi3_pkg::DET_W'(-det_ff) : det_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mat_ff[0] <= in_mat;
         for (int s = 1; s < FS; s++) begin
            mat_ff[s] <= mat_ff[s-1];
         end
         for (int i = 0; i < mi3_pkg::N_ELEM; i++) begin
            prod_ff[2*i]   <= $signed(mat_ff[0][mi3_pkg::COF_IDX[i][0]])
                            * $signed(mat_ff[0][mi3_pkg::COF_IDX[i][1]]);
            prod_ff[2*i+1] <= $signed(mat_ff[0][mi3_pkg::COF_IDX[i][2]])
                            * $signed(mat_ff[0][mi3_pkg::COF_IDX[i][3]]);
            cof_ff[3][i]   <= prod_ff[2*i] - prod_ff[2*i+1];
         end
         for (int s = 4; s <= FS; s++) begin
            cof_ff[s] <= cof_ff[s-1];
         end
         // split each 64-bit cofactor so every product is at most 33 by 32 bits
         for (int k = 0; k < 3; k++) begin
            ph_ff[k] <= $signed(cof_ff[3][k][63:32]) * $signed(mat_ff[2][3*k]);
            pl_ff[k] <= $signed({1'b0, cof_ff[3][k][31:0]}) * $signed(mat_ff[2][3*k]);
            pr_ff[k] <= $signed({ph_ff[k], 32'd0}) + 96'(pl_ff[k]);
         end
         det_ff  <= mi3_pkg::DET_W'(pr_ff[0]) + mi3_pkg::DET_W'(pr_ff[1])
                  + mi3_pkg::DET_W'(pr_ff[2]);
         dneg_ff <= det_ff[mi3_pkg::DET_W-1];
         dmag_ff <= dmag_in;
         sing_ff <= dmag_in <= mi3_pkg::DET_W'(thr);
      end
   end

   assign fo.valid    = vld_ff[FS-1];
   assign fo.singular = sing_ff;
   assign fo.dneg     = dneg_ff;
   assign fo.dmag     = dmag_ff;
   assign fo.cof      = cof_ff[FS];
   assign fo.mat      = mat_ff[FS-1];

endmodule

// ===== hw/rtl/mi3_lane.sv =====
// ----------------------------------------------------------------------------
// mi3_lane
// One inverse element: pipelined restoring divide, one quotient bit a stage.
// ----------------------------------------------------------------------------
module mi3_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                       clock,
   input  logic                                       adv,
   input  logic [mi3_pkg::COF_W-1:0]                  cof,
   input  logic                                       dneg,
   input  logic [mi3_pkg::DET_W-1:0]                  dmag,
   input  logic [mi3_pkg::QBITS:0][mi3_pkg::DET_W-1:0] dmag_line,
   output logic [mi3_pkg::ELEM_W-1:0]                 res
);

   localparam int QB    = mi3_pkg::QBITS;
   localparam int DW    = mi3_pkg::DET_W;
   localparam int NUM_W = mi3_pkg::COF_W + 2 * FRAC_BITS;

   logic [mi3_pkg::COF_W-1:0] cmag;
   logic [NUM_W-1:0]          num;
   logic [DW-1:0]             hi_ext;

   logic [DW-1:0]  rem_ff [QB+1];
   logic [QB-1:0]  lo_ff  [QB+1];
   logic [QB-1:0]  q_ff   [QB+1];
   logic           ovf_ff [QB+1];
   logic           neg_ff [QB+1];

   assign cmag   = cof[mi3_pkg::COF_W-1] ? -cof : cof;
   assign num    = NUM_W'(cmag) << (2 * FRAC_BITS);
   assign hi_ext = DW'(num[NUM_W-1:QB]);

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= hi_ext;
         lo_ff[0]  <= num[QB-1:0];
         q_ff[0]   <= '0;
         ovf_ff[0] <= hi_ext >= dmag;
         neg_ff[0] <= cof[mi3_pkg::COF_W-1] ^ dneg;
      end
   end

   for (genvar s = 0; s < QB; s++) begin : g_step
      logic [DW:0] trial;
      logic        ge;
      assign trial = {rem_ff[s], lo_ff[s][QB-1]};
      assign ge    = trial >= {1'b0, dmag_line[s]};
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s+1] <= ge ? DW'(trial - {1'b0, dmag_line[s]}) : trial[DW-1:0];
            lo_ff[s+1]  <= {lo_ff[s][QB-2:0], 1'b0};
            q_ff[s+1]   <= {q_ff[s][QB-2:0], ge};
            ovf_ff[s+1] <= ovf_ff[s];
            neg_ff[s+1] <= neg_ff[s];
         end
      end
   end

   // saturate to the signed 32-bit range
   always_comb begin
      if (neg_ff[QB]) begin
         if (ovf_ff[QB] || (q_ff[QB][QB-1] && |q_ff[QB][QB-2:0])) begin
            res = {1'b1, {(QB-1){1'b0}}};
         end else begin
            res = -q_ff[QB];
         end
      end else begin
         if (ovf_ff[QB] || q_ff[QB][QB-1]) begin
            res = {1'b0, {(QB-1){1'b1}}};
         end else begin
            res = q_ff[QB];
         end
      end
   end

endmodule

// ===== hw/rtl/matrix3x3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 fixed-point inverse by adjugate over determinant, nine divide lanes.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload
// req_    | in  | tdata: elem_r1c1 .. elem_r3c3, 32 bits each
// rsp_    | out | tdata: inv_r1c1 .. inv_r3c3; tuser: singular
// csr_    | in  | data: det_threshold, 48 bits
//
// One matrix per cycle unless rsp_ stalls; 7 front stages (products, cofactors,
// determinant), 33 divider stages (load, then one quotient bit each), 1 output.
// All stages advance together when the output register is empty or taken;
// a stalled rsp_ holds the whole pipeline and drops req_tready.
// Reset clears valid flags and sets the threshold to 2814750.
// ----------------------------------------------------------------------------
`include "matrix3x3_inverse_assert.svh"

module matrix3x3_inverse #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [287:0] req_tdata,   // elem_r1c1, r1c2, r1c3, r2c1 .. r3c3
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [287:0] rsp_tdata,   // inv_r1c1, r1c2, r1c3, r2c1 .. r3c3
   output logic [0:0]   rsp_tuser,   // singular
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [47:0]  csr_data
);

   localparam int QB = mi3_pkg::QBITS;

   logic                          adv;
   logic [mi3_pkg::THR_W-1:0]     thr_ff;
   mi3_pkg::front_out_type        fo;
   logic [QB:0][mi3_pkg::DET_W-1:0] dmag_ff;
   logic [QB:0]                   vl_ff;
   logic [QB:0]                   sing_ff;
   mi3_pkg::mat_type              mat_ff [QB+1];
   mi3_pkg::mat_type              res;
   logic                          out_valid_ff;
   mi3_pkg::mat_type              out_data_ff;
   logic                          out_sing_ff;

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= mi3_pkg::THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   mi3_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid),
      .in_mat   (req_tdata),
      .thr      (thr_ff),
      .fo       (fo)
   );

   for (genvar i = 0; i < mi3_pkg::N_ELEM; i++) begin : g_lane
      mi3_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock     (clock),
         .adv       (adv),
         .cof       (fo.cof[i]),
         .dneg      (fo.dneg),
         .dmag      (fo.dmag),
         .dmag_line (dmag_ff),
         .res       (res[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         vl_ff        <= {vl_ff[QB-1:0], fo.valid};
         out_valid_ff <= vl_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dmag_ff   <= {dmag_ff[QB-1:0], fo.dmag};
         sing_ff   <= {sing_ff[QB-1:0], fo.singular};
         mat_ff[0] <= fo.mat;
         for (int s = 1; s <= QB; s++) begin
            mat_ff[s] <= mat_ff[s-1];
         end
         // pass the input through when the determinant is too small
         out_data_ff <= sing_ff[QB] ? mat_ff[QB] : res;
         out_sing_ff <= sing_ff[QB];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_sing_ff;

   `MI3_ASSERT_IMPL(a_stall_blocks_req, rsp_tvalid && !rsp_tready, !req_tready, "req taken during output stall")
   `MI3_ASSERT_NEXT(a_last_to_out, adv && vl_ff[QB], rsp_tvalid, "item lost at output register")
   `MI3_ASSERT_IMPL(a_out_source, $rose(out_valid_ff), $past(vl_ff[QB]), "output without pipeline item")

endmodule

// ===== tb/matrix3x3_inverse_tb.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse_tb
// Streams 3x3 Q16.16 matrices into the inverter and predicts each result:
// the exact adjugate and determinant, the singular test against the
// threshold, and the truncated, saturated quotients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix3x3_inverse_tb;

   localparam int FRAC     = 16;
   localparam int LATENCY  = 41;
   localparam int WD_LIMIT = 20000;
   localparam int N_RANDOM = 930;

   typedef struct packed {
      logic             singular;
      mi3_pkg::mat_type inv;
   } inv_result_type;

   class inverse_scoreboard;
      inv_result_type pending[$];
      logic [mi3_pkg::THR_W-1:0] threshold;
      int errors;

      function new();
         threshold = mi3_pkg::THR_RESET;
         errors = 0;
      endfunction

      function automatic logic [31:0] divide_elem(logic signed [63:0] cof,
                                                  logic [97:0] dmag, logic dneg);
         logic [127:0] num;
         logic [127:0] q;
         logic neg;
         if (cof == 0) return 32'd0;
         num = {64'd0, (cof < 0) ? 64'(-cof) : 64'(cof)};
         num = num << (2 * FRAC);
         q = num / {30'd0, dmag};
         neg = (cof < 0) != dneg;
         if (neg) begin
            if (q > 128'h8000_0000) return 32'h8000_0000;
            return 32'(-q);
         end
         if (q > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
         return q[31:0];
      endfunction

      function void note_matrix(mi3_pkg::mat_type m);
         logic signed [63:0] e[9];
         logic signed [63:0] adj[9];
         logic signed [127:0] det;
         logic [127:0] dmag;
         inv_result_type r;
         for (int i = 0; i < 9; i++) e[i] = 64'(signed'(m[i]));
         adj[0] = e[4]*e[8] - e[5]*e[7];
         adj[1] = e[2]*e[7] - e[1]*e[8];
         adj[2] = e[1]*e[5] - e[2]*e[4];
         adj[3] = e[5]*e[6] - e[3]*e[8];
         adj[4] = e[0]*e[8] - e[2]*e[6];
         adj[5] = e[2]*e[3] - e[0]*e[5];
         adj[6] = e[3]*e[7] - e[4]*e[6];
         adj[7] = e[1]*e[6] - e[0]*e[7];
         adj[8] = e[0]*e[4] - e[1]*e[3];
         det = 128'(adj[0]) * 128'(e[0]) + 128'(adj[1]) * 128'(e[3])
             + 128'(adj[2]) * 128'(e[6]);
         dmag = (det < 0) ? 128'(-det) : 128'(det);
         if (dmag <= {80'd0, threshold}) begin
            r.inv = m;
            r.singular = 1'b1;
         end else begin
            for (int i = 0; i < 9; i++)
               r.inv[i] = divide_elem(adj[i], dmag[97:0], det < 0);
            r.singular = 1'b0;
         end
         pending.push_back(r);
      endfunction

      task check_result(mi3_pkg::mat_type inv, logic sing);
         inv_result_type exp_r;
         if (pending.size() == 0) begin
            report_error("result with nothing pending");
            return;
         end
         exp_r = pending.pop_front();
         for (int i = 0; i < 9; i++)
            if (inv[i] !== exp_r.inv[i])
               report_error($sformatf("element %0d: got %h want %h", i, inv[i],
                                      exp_r.inv[i]));
         if (sing !== exp_r.singular)
            report_error($sformatf("singular: got %b want %b", sing, exp_r.singular));
      endtask

      task report_error(string msg);
         errors++;
         $display("ERROR %0t: %s", $realtime, msg);
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [287:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [287:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [47:0]  csr_data = '0;

   inverse_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   matrix3x3_inverse i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // receiver: random stalls, check on each accepted item
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser[0]);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (board.pending.size() != 0 || req_tvalid || csr_valid)
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("matrix3x3_inverse regression: fail");
         $finish;
      end
   end

   // valid stays high after the item; the next send or the caller drops it
   task automatic send_matrix(mi3_pkg::mat_type m);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= m;
      do @(posedge clock); while (!req_tready);
      board.note_matrix(m);
   endtask

   task automatic write_threshold(logic [47:0] thr);
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= thr;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.threshold = thr;
   endtask

   function automatic logic [31:0] rand_elem();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'($urandom_range(4)) << 16 ^ {32{1'($urandom_range(1))}};
         2: return 32'(signed'($urandom_range(512)) - 256) <<< $urandom_range(16);
         3: return ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
         default: return 32'(signed'(int'($urandom_range(8))) - 4) <<< 16;
      endcase
   endfunction

   task automatic send_random(int count);
      mi3_pkg::mat_type m;
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 9; i++) m[i] = rand_elem();
         // make some rows dependent to land near the singular boundary
         if ($urandom_range(5) == 0)
            for (int i = 0; i < 3; i++) m[6+i] = m[i] ^ 32'($urandom_range(1));
         send_matrix(m);
      end
   endtask

   localparam logic [31:0] ONE = 32'h0001_0000;

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identity, zero, extremes, tiny, huge quotient, zero cofactor
      send_matrix({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
      send_matrix('0);
      send_matrix({9{32'h7FFF_FFFF}});
      send_matrix({9{32'h8000_0000}});
      send_matrix({32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0,
                   32'd0, 32'd0, 32'h8000_0000});
      send_matrix({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
      send_matrix({32'd300, 32'd0, 32'd0, 32'd0, 32'd300, 32'd0, 32'd0, 32'd0,
                   32'd300});
      send_matrix({32'hFFFF_FFFF, 32'd5, 32'd0, 32'd7, 32'hFFFF_0000, 32'd0,
                   32'd0, 32'd0, 32'h0002_0000});
      send_matrix({32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678, 32'h8765_4321,
                   32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_FFFF, 32'hFFFF_0000,
                   32'h7FFF_0001});
      send_matrix({ONE << 3, ONE, 32'd0, ONE, ONE << 1, ONE, 32'd0, ONE,
                   -(ONE << 2)});

      write_threshold(48'd0);
      send_matrix({32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1});
      send_matrix({32'd2, 32'd0, 32'd0, 32'd0, 32'd3, 32'd0, 32'd0, 32'd0, 32'd5});
      send_matrix('0);
      write_threshold(48'hFFFF_FFFF_FFFF);
      send_matrix({ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE});
      send_matrix({ONE << 9, 32'd0, 32'd0, 32'd0, ONE << 9, 32'd0, 32'd0, 32'd0,
                   ONE << 9});
      send_matrix({9{32'h7FFF_FFFF}});
      send_matrix({32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'd0,
                   32'd0, 32'd0, 32'h8000_0000});

      write_threshold(mi3_pkg::THR_RESET);
      send_idle_pct = 10;
      recv_idle_pct = 80;
      send_random(N_RANDOM / 3);
      write_threshold(48'($urandom()) << $urandom_range(16));
      send_idle_pct = 80;
      recv_idle_pct = 10;
      send_random(N_RANDOM / 3);
      write_threshold(48'd1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(N_RANDOM / 3);
      req_tvalid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (board.errors == 0)
         $display("matrix3x3_inverse regression: pass");
      else
         $display("matrix3x3_inverse regression: fail");
      $finish;
   end

endmodule
